[design/bba_pkg.sv]
package bba_pkg;

    // Operation codes of the op field.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RANGE     = 3'd1;
    localparam logic [2:0] ST_MISALIGN  = 3'd2;
    localparam logic [2:0] ST_ALREADY   = 3'd3;
    localparam logic [2:0] ST_NOSPACE   = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_FIRST  = 2'd0;
    localparam logic [1:0] CFG_COUNT  = 2'd1;
    localparam logic [1:0] CFG_LEVELS = 2'd2;

    // Width of a level number, enough for the largest level count.
    localparam int LVL_W = 5;

    typedef struct packed {
        logic [31:0] first_data_block;
        logic [10:0] data_block_count;
        logic [3:0]  level_count;
    } t_cfg;

endpackage

[design/bba_ram.sv]
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/bba_cfg.sv]
module bba_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output bba_pkg::t_cfg o_cfg
);

    bba_pkg::t_cfg r_cfg;
    logic          wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes; an address beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_data_block <= 32'd1;
            r_cfg.data_block_count <= 11'd1024;
            r_cfg.level_count      <= 4'd11;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                bba_pkg::CFG_FIRST:  r_cfg.first_data_block <= pwdata;
                bba_pkg::CFG_COUNT:  r_cfg.data_block_count <= pwdata[10:0];
                bba_pkg::CFG_LEVELS: r_cfg.level_count      <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        unique case (paddr[3:2])
            bba_pkg::CFG_FIRST:  prdata = r_cfg.first_data_block;
            bba_pkg::CFG_COUNT:  prdata = {21'd0, r_cfg.data_block_count};
            bba_pkg::CFG_LEVELS: prdata = {28'd0, r_cfg.level_count};
            default:             prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[design/buddy_bitmap_allocator.sv]
// Binary buddy allocator over a bitmap held in one RAM of SCAN_WORD_BITS-bit
// words, each level starting on a word boundary. After reset the block runs
// a clearing pass that sets every bit (all chunks used), one RAM word per
// cycle. Each level is rounded up to whole words, so by default this is 68
// words, and the block accepts no word until the pass ends. Each item is
// then handled one at a time by a small sequencer around one RAM
// read-modify-write. An allocate scans the words of the requested level
// and of each higher level until it finds a free bit, then splits down
// one level per word access. A free checks the chunk and its ancestors,
// at most one RAM access per level, then merges buddies upward one level
// per access. Errors found from the registers alone go straight to the
// result. A finished result waits in the output register while the next
// word is accepted.
module buddy_bitmap_allocator #(
    parameter int MAX_BLOCKS     = 1024,
    parameter int MAX_LEVELS     = 11,
    parameter int SCAN_WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [31:0] i_disk_block,
    input  logic [3:0]  i_size_log2,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_granted_block,
    output logic [2:0]  o_status
);

    localparam int W   = SCAN_WORD_BITS;
    localparam int WL  = $clog2(W);
    localparam int SW  = $clog2(MAX_BLOCKS + 1);
    localparam int IXW = (SW > WL + 1) ? SW : WL + 1;
    localparam int LIW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int LW  = bba_pkg::LVL_W;

    function automatic int lvl_words(int lv);
        return ((MAX_BLOCKS >> lv) + W - 1) / W;
    endfunction

    function automatic int total_words();
        int acc;
        acc = 0;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            acc += lvl_words(l);
        end
        return acc;
    endfunction

    localparam int DEPTH = total_words();
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(DEPTH + 1);

    function automatic logic [MAX_LEVELS-1:0][AW-1:0] base_table();
        logic [MAX_LEVELS-1:0][AW-1:0] t;
        int acc;
        acc = 0;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            t[l] = AW'(acc);
            acc += lvl_words(l);
        end
        return t;
    endfunction

    function automatic logic [MAX_LEVELS-1:0][WW-1:0] words_table();
        logic [MAX_LEVELS-1:0][WW-1:0] t;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            t[l] = WW'(lvl_words(l));
        end
        return t;
    endfunction

    function automatic logic [MAX_LEVELS-1:0][SW-1:0] size_table();
        logic [MAX_LEVELS-1:0][SW-1:0] t;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            t[l] = SW'(MAX_BLOCKS >> l);
        end
        return t;
    endfunction

    localparam logic [MAX_LEVELS-1:0][AW-1:0] BASE_W  = base_table();
    localparam logic [MAX_LEVELS-1:0][WW-1:0] WORDS_T = words_table();
    localparam logic [MAX_LEVELS-1:0][SW-1:0] SIZE_T  = size_table();

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SPLIT_RD, S_SPLIT_WR,
        S_CHK_RD, S_CHK_TST, S_MRG_RD, S_MRG_WR, S_DONE
    } t_state;

    bba_pkg::t_cfg cfg;

    t_state         r_state, n_state;
    logic [AW-1:0]  r_clr_addr, n_clr_addr;
    logic           r_op, n_op;
    logic [3:0]     r_sz, n_sz;
    logic [LW-1:0]  r_lv, n_lv;
    logic [IXW-1:0] r_idx, n_idx;
    logic [31:0]    r_off, n_off;
    logic [2:0]     r_res, n_res;
    logic           r_out_valid, n_out_valid;
    logic [31:0]    r_granted, n_granted;
    logic [2:0]     r_out_status, n_out_status;

    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [W-1:0]   ram_wdata, ram_rdata;

    logic [LW-1:0]  nlv;
    logic [LIW-1:0] lv_i;
    logic [31:0]    chk_full;
    logic [IXW-1:0] cur_idx;
    logic [AW-1:0]  cur_addr;
    logic [WL-1:0]  pos, bpos;
    logic [W-1:0]   pos_bit, bpos_bit;
    logic           fz_hit;
    logic [WL-1:0]  fz_pos;
    logic [31:0]    off_in;
    logic [32:0]    off_end, dbc33;
    logic           in_acc, out_free;

    bba_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bba_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Effective level count and the current bit position.
    assign nlv = (LW'(cfg.level_count) < LW'(MAX_LEVELS)) ?
                 LW'(cfg.level_count) : LW'(MAX_LEVELS);
    assign lv_i     = r_lv[LIW-1:0];
    assign chk_full = r_off >> r_lv;
    assign cur_idx  = (r_state == S_CHK_RD || r_state == S_CHK_TST) ?
                      chk_full[IXW-1:0] : r_idx;
    assign cur_addr = BASE_W[lv_i] + AW'(cur_idx >> WL);
    assign pos      = cur_idx[WL-1:0];
    assign bpos     = pos ^ WL'(1);
    assign pos_bit  = {{(W-1){1'b0}}, 1'b1} << pos;
    assign bpos_bit = {{(W-1){1'b0}}, 1'b1} << bpos;

    // Lowest clear bit of the word read back.
    always_comb begin
        fz_hit = 1'b0;
        fz_pos = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (!ram_rdata[i]) begin
                fz_hit = 1'b1;
                fz_pos = WL'(i);
            end
        end
    end

    // Range of a chunk to free.
    assign off_in  = i_disk_block - cfg.first_data_block;
    assign off_end = {1'b0, off_in} + (33'd1 << i_size_log2);
    assign dbc33   = (33'(cfg.data_block_count) > 33'(MAX_BLOCKS)) ?
                     33'(MAX_BLOCKS) : 33'(cfg.data_block_count);

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_op         = r_op;
        n_sz         = r_sz;
        n_lv         = r_lv;
        n_idx        = r_idx;
        n_off        = r_off;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_granted    = r_granted;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = cur_addr;
        ram_raddr    = cur_addr;
        ram_wdata    = ram_rdata;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '1;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_op  = i_operation;
                    n_sz  = i_size_log2;
                    n_lv  = LW'(i_size_log2);
                    n_idx = '0;
                    n_off = off_in;
                    n_res = bba_pkg::ST_OK;
                    if (i_operation == bba_pkg::OP_ALLOC) begin
                        if (LW'(i_size_log2) >= nlv) begin
                            n_res   = bba_pkg::ST_NOSPACE;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end else if (LW'(i_size_log2) >= nlv ||
                                 i_disk_block < cfg.first_data_block ||
                                 off_end > dbc33) begin
                        n_res   = bba_pkg::ST_RANGE;
                        n_state = S_DONE;
                    end else if ((off_in & ((32'd1 << i_size_log2) - 32'd1)) != 32'd0)
                    begin
                        n_res   = bba_pkg::ST_MISALIGN;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_CHK_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (WORDS_T[lv_i] == WW'(0)) begin
                    n_res   = bba_pkg::ST_NOSPACE;
                    n_state = S_DONE;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (fz_hit) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | ({{(W-1){1'b0}}, 1'b1} << fz_pos);
                    if (r_lv > LW'(r_sz)) begin
                        n_lv    = r_lv - LW'(1);
                        n_idx   = (r_idx | IXW'(fz_pos)) << 1;
                        n_state = S_SPLIT_RD;
                    end else begin
                        n_idx   = r_idx | IXW'(fz_pos);
                        n_state = S_DONE;
                    end
                end else if (WW'(r_idx >> WL) + WW'(1) == WORDS_T[lv_i]) begin
                    if (r_lv + LW'(1) < nlv) begin
                        n_lv    = r_lv + LW'(1);
                        n_idx   = '0;
                        n_state = S_SCAN_RD;
                    end else begin
                        n_res   = bba_pkg::ST_NOSPACE;
                        n_state = S_DONE;
                    end
                end else begin
                    n_idx   = r_idx + IXW'(W);
                    n_state = S_SCAN_RD;
                end
            end
            S_SPLIT_RD: begin
                ram_re  = 1'b1;
                n_state = S_SPLIT_WR;
            end
            S_SPLIT_WR: begin
                // Lower half stays used, the upper-half buddy becomes free.
                ram_we    = 1'b1;
                ram_wdata = (ram_rdata | pos_bit) & ~bpos_bit;
                if (r_lv > LW'(r_sz)) begin
                    n_lv    = r_lv - LW'(1);
                    n_idx   = r_idx << 1;
                    n_state = S_SPLIT_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CHK_RD: begin
                if (chk_full >= 32'(SIZE_T[lv_i])) begin
                    // A chunk beyond the level counts as used.
                    if (r_lv + LW'(1) < nlv) begin
                        n_lv = r_lv + LW'(1);
                    end else begin
                        n_lv    = LW'(r_sz);
                        n_idx   = IXW'(r_off >> r_sz);
                        n_state = S_MRG_RD;
                    end
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_CHK_TST;
                end
            end
            S_CHK_TST: begin
                if (!ram_rdata[pos]) begin
                    n_res   = bba_pkg::ST_ALREADY;
                    n_state = S_DONE;
                end else if (r_lv + LW'(1) < nlv) begin
                    n_lv    = r_lv + LW'(1);
                    n_state = S_CHK_RD;
                end else begin
                    n_lv    = LW'(r_sz);
                    n_idx   = IXW'(r_off >> r_sz);
                    n_state = S_MRG_RD;
                end
            end
            S_MRG_RD: begin
                ram_re  = 1'b1;
                n_state = S_MRG_WR;
            end
            S_MRG_WR: begin
                ram_we = 1'b1;
                if (r_lv + LW'(1) < nlv &&
                    SW'(r_idx ^ IXW'(1)) < SIZE_T[lv_i] &&
                    (r_idx ^ IXW'(1)) < IXW'(SIZE_T[lv_i]) &&
                    !ram_rdata[bpos]) begin
                    // Both buddies merge into the parent, which is freed next.
                    ram_wdata = ram_rdata | pos_bit | bpos_bit;
                    n_lv      = r_lv + LW'(1);
                    n_idx     = r_idx >> 1;
                    n_state   = S_MRG_RD;
                end else begin
                    ram_wdata = ram_rdata & ~pos_bit;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res;
                    n_granted    = (r_op == bba_pkg::OP_ALLOC && r_res == bba_pkg::ST_OK) ?
                                   cfg.first_data_block + (32'(r_idx) << r_sz) : 32'd0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_sz         <= n_sz;
        r_lv         <= n_lv;
        r_idx        <= n_idx;
        r_off        <= n_off;
        r_res        <= n_res;
        r_granted    <= n_granted;
        r_out_status <= n_out_status;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_granted_block = r_granted;
    assign o_status        = r_out_status;

endmodule

[design/bba_chk.sv]
module bba_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_granted_block,
    input logic [2:0]  o_status
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_granted_block)
        && $stable(o_status))
        else $error("result word changed while stalled");

    // Only one word is worked on at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    // A failed request grants no block.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != bba_pkg::ST_OK |-> o_granted_block == 32'd0)
        else $error("block granted on failure");

    // No result right after reset.
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown after reset");

endmodule

bind buddy_bitmap_allocator bba_chk u_bba_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_granted_block (o_granted_block),
    .o_status        (o_status)
);

[tb/sv/buddy_bitmap_allocator_tb.sv]
module buddy_bitmap_allocator_tb;

    localparam int NUM_BLOCKS = 1024;
    localparam int NUM_LEVELS = 11;
    localparam int MAP_BITS   = 2 * NUM_BLOCKS;
    localparam int IDLE_LIMIT = 20000;

    // Expected result of one allocate or free word.
    typedef struct {
        logic [31:0] granted;
        logic [2:0]  status;
    } t_alloc_result;

    // Predicts the allocator and holds the results still owed by the block.
    class alloc_scoreboard;
        bit            bitmap [MAP_BITS];
        int            level_base [NUM_LEVELS + 1];
        logic [31:0]   first_block;
        logic [10:0]   block_count;
        logic [3:0]    levels;
        t_alloc_result pending [$];
        int            errors;
        logic [31:0]   last_grant;
        int            last_grant_size;
        bit            have_grant;

        function new();
            int acc;
            acc = 0;
            for (int lv = 0; lv <= NUM_LEVELS; lv++) begin
                level_base[lv] = acc;
                acc += level_width(lv);
            end
            foreach (bitmap[i]) bitmap[i] = 1'b1;
            first_block = 32'd1;
            block_count = 11'd1024;
            levels      = 4'd11;
            errors      = 0;
            have_grant  = 0;
        endfunction

        function int level_width(int lv);
            return (lv < NUM_LEVELS) ? (NUM_BLOCKS >> lv) : 0;
        endfunction

        function bit get_bit(int lv, longint idx);
            if (lv >= NUM_LEVELS || idx < 0 || idx >= level_width(lv)) return 1'b1;
            return bitmap[level_base[lv] + idx];
        endfunction

        function void put_bit(int lv, longint idx, bit v);
            if (lv >= NUM_LEVELS || idx < 0 || idx >= level_width(lv)) return;
            bitmap[level_base[lv] + idx] = v;
        endfunction

        function void write_reg(logic [1:0] index, logic [31:0] value);
            case (index)
                bba_pkg::CFG_FIRST:  first_block = value;
                bba_pkg::CFG_COUNT:  block_count = value[10:0];
                bba_pkg::CFG_LEVELS: levels = value[3:0];
                default: ;
            endcase
        endfunction

        // Note an accepted word and queue the result it must produce.
        function void note_request(logic op, logic [31:0] blk, logic [3:0] sz);
            t_alloc_result r;
            int nlv, lv, dbc;
            longint idx, off;
            bit hit, freed;
            nlv = (levels < NUM_LEVELS) ? levels : NUM_LEVELS;
            r.granted = 32'd0;
            r.status  = bba_pkg::ST_OK;
            if (op == bba_pkg::OP_ALLOC) begin
                hit = 0;
                idx = 0;
                for (lv = sz; lv < nlv; lv++) begin
                    for (int i = 0; i < level_width(lv); i++) begin
                        if (!get_bit(lv, i)) begin
                            idx = i;
                            hit = 1;
                            break;
                        end
                    end
                    if (hit) break;
                end
                if (!hit) begin
                    r.status = bba_pkg::ST_NOSPACE;
                end else begin
                    put_bit(lv, idx, 1'b1);
                    // Split down, leaving each upper buddy free.
                    while (lv > sz) begin
                        lv--;
                        idx = idx << 1;
                        put_bit(lv, idx, 1'b1);
                        put_bit(lv, idx + 1, 1'b0);
                    end
                    r.granted = first_block + 32'(idx << sz);
                    last_grant = r.granted;
                    last_grant_size = sz;
                    have_grant = 1;
                end
            end else begin
                dbc = (block_count < NUM_BLOCKS) ? block_count : NUM_BLOCKS;
                off = longint'(blk) - longint'(first_block);
                if (sz >= nlv || blk < first_block || off + (64'd1 << sz) > dbc) begin
                    r.status = bba_pkg::ST_RANGE;
                end else if ((off & ((64'd1 << sz) - 1)) != 0) begin
                    r.status = bba_pkg::ST_MISALIGN;
                end else begin
                    idx = off >> sz;
                    freed = 0;
                    for (lv = sz; lv < nlv; lv++) begin
                        if (!get_bit(lv, off >> lv)) begin
                            freed = 1;
                            break;
                        end
                    end
                    if (freed) begin
                        r.status = bba_pkg::ST_ALREADY;
                    end else begin
                        lv = sz;
                        put_bit(lv, idx, 1'b0);
                        // Merge free buddy pairs upward.
                        while (lv + 1 < nlv && (idx ^ 1) < level_width(lv) &&
                               !get_bit(lv, idx ^ 1)) begin
                            put_bit(lv, idx, 1'b1);
                            put_bit(lv, idx ^ 1, 1'b1);
                            lv++;
                            idx = idx >> 1;
                            put_bit(lv, idx, 1'b0);
                        end
                    end
                end
            end
            pending.push_back(r);
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(logic [31:0] granted, logic [2:0] status);
            t_alloc_result r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result granted=%h status=%0d",
                         $time, granted, status);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (granted !== r.granted) begin
                $display("%0t: granted_block expected %h actual %h",
                         $time, r.granted, granted);
                errors++;
            end
            if (status !== r.status) begin
                $display("%0t: status expected %0d actual %0d", $time, r.status, status);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_operation;
    logic [31:0] i_disk_block;
    logic [3:0]  i_size_log2;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_granted_block;
    logic [2:0]  o_status;

    alloc_scoreboard sb;
    bit   hold_off;
    int   idle_cycles;

    buddy_bitmap_allocator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_disk_block    (i_disk_block),
        .i_size_log2     (i_size_log2),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_granted_block (o_granted_block),
        .o_status        (o_status)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("buddy_bitmap_allocator_tb: FAIL");
            $finish;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_granted_block, o_status);
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int gap;
        i_out_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                i_out_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_off = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Register write: setup, access, then idle.
    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(index, value);
        @(posedge i_clk);
    endtask

    // Offer one word after a random gap and wait until it is taken. Valid
    // stays high afterwards until the next word or an idle period replaces it.
    task automatic send_word(logic op, logic [31:0] blk, logic [3:0] sz, bit no_gap = 0);
        int gap;
        gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_disk_block <= blk;
        i_size_log2  <= sz;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(op, blk, sz);
    endtask

    // Stop offering, wait until every expected result has arrived, then settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Free every block of the data area with random chunk sizes where aligned.
    task automatic free_area(int count, int nlv);
        int pos, sz;
        pos = 0;
        while (pos < count) begin
            sz = $urandom_range(0, nlv - 1);
            while (sz > 0 && ((pos % (1 << sz)) != 0 || pos + (1 << sz) > count)) sz--;
            send_word(bba_pkg::OP_FREE, sb.first_block + 32'(pos), 4'(sz));
            pos += 1 << sz;
        end
    endtask

    // Mostly valid allocate and free traffic with some malformed frees.
    task automatic random_traffic(int n, int nlv, int count);
        logic [31:0] blk;
        int sz, kind;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 9);
            sz = $urandom_range(0, 10);
            if (kind < 5) begin
                if (sz >= nlv && $urandom_range(0, 3) != 0) sz = $urandom_range(0, nlv - 1);
                send_word(bba_pkg::OP_ALLOC, $urandom(), 4'(sz));
            end else if (kind < 8 && sb.have_grant) begin
                send_word(bba_pkg::OP_FREE, sb.last_grant, 4'(sb.last_grant_size));
                sb.have_grant = 0;
            end else if (kind < 9) begin
                if (sz >= nlv) sz = $urandom_range(0, nlv - 1);
                blk = sb.first_block + 32'(($urandom_range(0, count - 1) >> sz) << sz);
                send_word(bba_pkg::OP_FREE, blk, 4'(sz));
            end else begin
                send_word(bba_pkg::OP_FREE, $urandom(), 4'($urandom_range(0, 15)));
            end
        end
    endtask

    // Stimulus.
    initial begin
        sb          = new();
        hold_off    = 0;
        idle_cycles = 0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = 4'd0;
        pwdata       = 32'd0;
        i_in_valid   = 1'b0;
        i_operation  = bba_pkg::OP_ALLOC;
        i_disk_block = 32'd0;
        i_size_log2  = 4'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: nothing free yet, then edge cases of range and alignment.
        send_word(bba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 4'd0);
        send_word(bba_pkg::OP_ALLOC, 32'd0, 4'd10);
        send_word(bba_pkg::OP_ALLOC, 32'd0, 4'd15);
        send_word(bba_pkg::OP_FREE, 32'd0, 4'd0);
        send_word(bba_pkg::OP_FREE, 32'hFFFF_FFFF, 4'd0);
        send_word(bba_pkg::OP_FREE, 32'd2, 4'd1);
        send_word(bba_pkg::OP_FREE, 32'd1, 4'd11);
        send_word(bba_pkg::OP_FREE, 32'd1, 4'd15);
        send_word(bba_pkg::OP_FREE, 32'd1, 4'd10);
        send_word(bba_pkg::OP_FREE, 32'd1, 4'd10);
        send_word(bba_pkg::OP_FREE, 32'd1, 4'd0);
        send_word(bba_pkg::OP_ALLOC, 32'd0, 4'd10);
        send_word(bba_pkg::OP_ALLOC, 32'd0, 4'd0);
        send_word(bba_pkg::OP_ALLOC, 32'd0, 4'd3);
        send_word(bba_pkg::OP_FREE, 32'd2, 4'd1);
        send_word(bba_pkg::OP_FREE, 32'd1, 4'd0);
        send_word(bba_pkg::OP_FREE, 32'd9, 4'd3);
        send_word(bba_pkg::OP_FREE, 32'd1025, 4'd0);
        send_word(bba_pkg::OP_FREE, 32'd1024, 4'd0);
        drain();

        // Phase: high base near wrap, small area, few levels.
        write_reg(bba_pkg::CFG_FIRST, 32'hFFFF_FF00);
        write_reg(bba_pkg::CFG_COUNT, 32'd100);
        write_reg(bba_pkg::CFG_LEVELS, 32'd4);
        free_area(100, 4);
        random_traffic(80, 4, 100);
        drain();

        // Phase: one level and one block, the smallest nonzero settings.
        write_reg(bba_pkg::CFG_FIRST, 32'd1);
        write_reg(bba_pkg::CFG_COUNT, 32'd1);
        write_reg(bba_pkg::CFG_LEVELS, 32'd1);
        random_traffic(20, 1, 1);
        drain();

        // Phase: level count above the maximum, count at the field maximum.
        write_reg(bba_pkg::CFG_FIRST, 32'h1234_5678);
        write_reg(bba_pkg::CFG_COUNT, 32'h7FF);
        write_reg(bba_pkg::CFG_LEVELS, 32'hF);
        free_area(1024, 11);
        // Receiver holds off while the sender keeps offering words.
        hold_off = 1;
        for (int k = 0; k < 8; k++) send_word(bba_pkg::OP_ALLOC, 32'd0, 4'd0, 1);
        random_traffic(100, 11, 1024);
        drain();

        // Phase: zero count and level registers, then a mid setting with random content.
        write_reg(bba_pkg::CFG_COUNT, 32'd0);
        write_reg(bba_pkg::CFG_LEVELS, 32'd0);
        random_traffic(20, 1, 1);
        drain();
        write_reg(bba_pkg::CFG_FIRST, $urandom());
        write_reg(bba_pkg::CFG_COUNT, 32'd1024);
        write_reg(bba_pkg::CFG_LEVELS, 32'd7);
        random_traffic(100, 7, 1024);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("buddy_bitmap_allocator_tb: PASS");
        end else begin
            $display("buddy_bitmap_allocator_tb: FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
design/bba_pkg.sv
design/bba_ram.sv
design/bba_cfg.sv
design/buddy_bitmap_allocator.sv
design/bba_chk.sv
tb/sv/buddy_bitmap_allocator_tb.sv
